### sv/tsra_pkg.sv
// Shared widths and word types for the trade side run aggregator.
`timescale 1ns / 1ps

package tsra_pkg;

    localparam int PRICE_W    = 32;
    localparam int QTY_W      = 32;
    localparam int QSUM_W     = 40;
    localparam int VOL_W      = 63;
    localparam int ID_W       = 63;
    localparam int TIME_W     = 63;
    localparam int PROD_W     = PRICE_W + QTY_W;

    // output queue: a trade can push two words in one cycle
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = FIFO_AW + 1;
    localparam int PUSH_W     = 2;

    // one run as held in the accumulator
    typedef struct packed {
        logic              side;
        logic [PRICE_W-1:0] first_price;
        logic [PRICE_W-1:0] final_price;
        logic [QSUM_W-1:0]  qty_sum;
        logic [VOL_W-1:0]   vol_sum;
        logic [ID_W-1:0]    first_id;
        logic [ID_W-1:0]    final_id;
        logic [TIME_W-1:0]  first_time;
        logic [TIME_W-1:0]  final_time;
    } t_run_state;

    // one finished run word
    typedef struct packed {
        t_run_state run;
        logic       last;
    } t_run;

    // push request into the output queue
    typedef struct packed {
        logic [PUSH_W-1:0] count;
        t_run              word0;
        t_run              word1;
    } t_push;

endpackage

### sv/tsra_trade_if.sv
// Trade input channel: valid/ready plus one trade.
`timescale 1ns / 1ps

interface tsra_trade_if;
    logic                          valid;
    logic                          ready;
    logic                          trade_side;
    logic [tsra_pkg::PRICE_W-1:0]  trade_price;
    logic [tsra_pkg::QTY_W-1:0]    trade_quantity;
    logic [tsra_pkg::ID_W-1:0]     trade_ref;
    logic [tsra_pkg::TIME_W-1:0]   trade_time;
    logic                          end_of_batch;

    modport source (
        output valid, trade_side, trade_price, trade_quantity, trade_ref, trade_time,
               end_of_batch,
        input  ready
    );
    modport sink (
        input  valid, trade_side, trade_price, trade_quantity, trade_ref, trade_time,
               end_of_batch,
        output ready
    );
endinterface

### sv/tsra_cfg_if.sv
// Configuration write channel: valid/ready plus the minimum trade id.
`timescale 1ns / 1ps

interface tsra_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [tsra_pkg::ID_W-1:0]  min_id;

    modport source (output valid, min_id, input ready);
    modport sink   (input valid, min_id, output ready);
endinterface

### sv/tsra_run_if.sv
// Run output channel: valid/ready plus one finished run.
`timescale 1ns / 1ps

interface tsra_run_if;
    logic                          valid;
    logic                          ready;
    logic                          run_is_buy;
    logic [tsra_pkg::PRICE_W-1:0]  first_price;
    logic [tsra_pkg::PRICE_W-1:0]  final_price;
    logic [tsra_pkg::QSUM_W-1:0]   total_quantity;
    logic [tsra_pkg::VOL_W-1:0]    total_volume;
    logic [tsra_pkg::ID_W-1:0]     first_id;
    logic [tsra_pkg::ID_W-1:0]     final_id;
    logic [tsra_pkg::TIME_W-1:0]   first_time;
    logic [tsra_pkg::TIME_W-1:0]   final_time;
    logic                          last_of_batch;

    modport source (
        output valid, run_is_buy, first_price, final_price, total_quantity, total_volume,
               first_id, final_id, first_time, final_time, last_of_batch,
        input  ready
    );
    modport sink (
        input  valid, run_is_buy, first_price, final_price, total_quantity, total_volume,
               first_id, final_id, first_time, final_time, last_of_batch,
        output ready
    );
endinterface

### sv/tsra_out_fifo.sv
// Output queue for run words: up to two pushes and one pop per cycle.
`timescale 1ns / 1ps

module tsra_out_fifo (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  tsra_pkg::t_push           i_push,
    output logic                      o_room,
    output logic                      o_valid,
    output tsra_pkg::t_run            o_word,
    input  logic                      i_ready
);
    import tsra_pkg::*;

    t_run                r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]  r_wr;
    logic [FIFO_AW-1:0]  r_rd;
    logic [FIFO_CW-1:0]  r_count;
    logic [FIFO_AW-1:0]  n_wr;
    logic [FIFO_AW-1:0]  n_rd;
    logic [FIFO_CW-1:0]  n_count;
    logic [FIFO_AW-1:0]  wr_next;
    logic                pop;

    assign o_valid = (r_count != '0);
    assign o_word  = r_mem[r_rd];
    assign o_room  = (r_count <= FIFO_CW'(FIFO_DEPTH - 2));
    assign pop     = o_valid & i_ready;
    assign wr_next = r_wr + FIFO_AW'(1);

    always_comb begin
        n_wr    = r_wr + FIFO_AW'(i_push.count);
        n_rd    = r_rd + FIFO_AW'(pop);
        n_count = r_count + FIFO_CW'(i_push.count) - FIFO_CW'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push.count != '0) begin
            r_mem[r_wr] <= i_push.word0;
        end
        if (i_push.count == PUSH_W'(2)) begin
            r_mem[wr_next] <= i_push.word1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    // a push never lands on a live word
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push.count != '0) |-> ((r_count + FIFO_CW'(i_push.count)) <= FIFO_CW'(FIFO_DEPTH)))
        else $error("output queue overrun");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FIFO_CW'(FIFO_DEPTH))
        else $error("output queue count out of range");

    // pushes only arrive while room for two words is flagged
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push.count != '0) |-> o_room)
        else $error("push without room");

endmodule

### sv/trade_side_run_aggregator_unit.sv
// Top level: trade filter, run accumulator and output queue.
`timescale 1ns / 1ps

// Trade side run aggregator.
// Channels: i_trade takes one trade word per accepted cycle; o_run gives one
// finished run word per accepted cycle; i_cfg writes the minimum trade id
// (always ready, write only while the block is idle).
// Pipeline: stage A registers the trade, the id filter result and the clamped
// price*quantity product. Stage B merges the trade into the open run and
// pushes zero, one or two run words into a four-word output queue.
// Order: the closing trade is registered in stage A, then its run words are written to the queue.
// Throughput: one trade per cycle while o_run.ready is high and trades cause at
// most one word each; a trade that both changes side and ends a batch pushes two
// words, and the single output port drains them at one word a cycle.
// Stall: when o_run.ready is low the queue fills, stage B holds once fewer
// than two free slots remain, and i_trade.ready drops behind it.
// Reset: i_rst_n (synchronous) empties both stages and the queue, closes the
// open run and sets the minimum trade id to zero.
module trade_side_run_aggregator_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    tsra_trade_if.sink   i_trade,
    tsra_cfg_if.sink     i_cfg,
    tsra_run_if.source   o_run
);
    import tsra_pkg::*;

    typedef struct packed {
        logic               side;
        logic [PRICE_W-1:0] price;
        logic [QTY_W-1:0]   qty;
        logic [ID_W-1:0]    id;
        logic [TIME_W-1:0]  tm;
        logic               eob;
        logic               pass;
        logic [VOL_W-1:0]   vol;
    } t_stage_a;

    logic [ID_W-1:0]  r_min_id;
    logic             r_a_valid;
    t_stage_a         r_a;
    t_stage_a         n_a;
    logic             r_run_open;
    logic             n_run_open;
    t_run_state       r_run;
    t_run_state       n_run;

    logic [PROD_W-1:0] prod;
    logic              in_fire;
    logic              b_fire;
    logic              fifo_room;
    logic              same_side;
    logic              emit_prev;
    logic              emit_flush;
    logic              open_after;
    logic [QSUM_W:0]   qty_add;
    logic [VOL_W:0]    vol_add;
    logic [QSUM_W-1:0] qty_sat;
    logic [VOL_W-1:0]  vol_sat;
    t_push             push;
    t_run              out_word;
    t_run              prev_word;
    t_run              flush_word;

    // config: single register, always ready
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_id <= '0;
        end else if (i_cfg.valid) begin
            r_min_id <= i_cfg.min_id;
        end
    end

    // stage A: filter compare and product, side by side
    assign in_fire       = i_trade.valid & i_trade.ready;
    assign i_trade.ready = !r_a_valid || b_fire;
    assign prod          = PROD_W'(i_trade.trade_price) * PROD_W'(i_trade.trade_quantity);

    always_comb begin
        n_a.side  = i_trade.trade_side;
        n_a.price = i_trade.trade_price;
        n_a.qty   = i_trade.trade_quantity;
        n_a.id    = i_trade.trade_ref;
        n_a.tm    = i_trade.trade_time;
        n_a.eob   = i_trade.end_of_batch;
        n_a.pass  = (i_trade.trade_ref >= r_min_id);
        // clamp a product at or above 2^63
        n_a.vol   = prod[PROD_W-1] ? '1 : prod[VOL_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (i_trade.ready) begin
            r_a_valid <= in_fire;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_a <= n_a;
        end
    end

    // stage B: run update
    assign b_fire     = r_a_valid & fifo_room;
    assign same_side  = r_run_open && (r_run.side == r_a.side);
    assign emit_prev  = r_a.pass && r_run_open && !same_side;
    assign open_after = r_a.pass || r_run_open;
    assign emit_flush = r_a.eob && open_after;

    assign qty_add = {1'b0, r_run.qty_sum} + (QSUM_W + 1)'(r_a.qty);
    assign vol_add = {1'b0, r_run.vol_sum} + {1'b0, r_a.vol};
    assign qty_sat = qty_add[QSUM_W] ? '1 : qty_add[QSUM_W-1:0];
    assign vol_sat = vol_add[VOL_W]  ? '1 : vol_add[VOL_W-1:0];

    always_comb begin
        n_run = r_run;
        if (r_a.pass) begin
            if (same_side) begin
                n_run.final_price = r_a.price;
                n_run.final_id    = r_a.id;
                n_run.final_time  = r_a.tm;
                n_run.qty_sum     = qty_sat;
                n_run.vol_sum     = vol_sat;
            end else begin
                n_run.side        = r_a.side;
                n_run.first_price = r_a.price;
                n_run.final_price = r_a.price;
                n_run.qty_sum     = QSUM_W'(r_a.qty);
                n_run.vol_sum     = r_a.vol;
                n_run.first_id    = r_a.id;
                n_run.final_id    = r_a.id;
                n_run.first_time  = r_a.tm;
                n_run.final_time  = r_a.tm;
            end
        end
        n_run_open = open_after && !r_a.eob;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_open <= 1'b0;
        end else if (b_fire) begin
            r_run_open <= n_run_open;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_fire) begin
            r_run <= n_run;
        end
    end

    // words: the closed run of the other side first, then the batch flush
    always_comb begin
        prev_word.run  = r_run;
        prev_word.last = 1'b0;
        flush_word.run  = n_run;
        flush_word.last = 1'b1;
        push.word0 = emit_prev ? prev_word : flush_word;
        push.word1 = flush_word;
        push.count = b_fire ? (PUSH_W'(emit_prev) + PUSH_W'(emit_flush)) : '0;
    end

    tsra_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (fifo_room),
        .o_valid (o_run.valid),
        .o_word  (out_word),
        .i_ready (o_run.ready)
    );

    assign o_run.run_is_buy     = out_word.run.side;
    assign o_run.first_price    = out_word.run.first_price;
    assign o_run.final_price    = out_word.run.final_price;
    assign o_run.total_quantity = out_word.run.qty_sum;
    assign o_run.total_volume   = out_word.run.vol_sum;
    assign o_run.first_id       = out_word.run.first_id;
    assign o_run.final_id       = out_word.run.final_id;
    assign o_run.first_time     = out_word.run.first_time;
    assign o_run.final_time     = out_word.run.final_time;
    assign o_run.last_of_batch  = out_word.last;

    // a batch end always leaves no run open
    a_flush_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (b_fire && r_a.eob) |=> !r_run_open)
        else $error("run still open after batch end");

    // a trade waiting in stage A is neither lost nor altered
    a_stage_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_a_valid && !b_fire) |=> (r_a_valid && $stable(r_a)))
        else $error("stage A word lost while stalled");

    // two words only when a run closes on side change and the new one flushes
    a_two_words: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push.count == PUSH_W'(2)) |-> (r_a.pass && r_a.eob && r_run_open))
        else $error("double push without side change and flush");

endmodule

### tb/trade_side_run_aggregator_unit_test.sv
// Self-checking testbench for the trade side run aggregator top level.
`timescale 1ns / 1ps

module trade_side_run_aggregator_unit_test;

    import tsra_pkg::*;

    localparam logic [62:0] ID_MAX  = {63{1'b1}};
    localparam logic [39:0] QTY_SAT = {40{1'b1}};
    localparam logic [62:0] VOL_SAT = {63{1'b1}};
    localparam int          SETTLE_CYCLES = 6;   // pipeline is two deep, leave margin

    // one trade as offered on the input channel
    typedef struct packed {
        logic        side;
        logic [31:0] price;
        logic [31:0] quantity;
        logic [62:0] id;
        logic [62:0] stamp;
        logic        eob;
    } t_trade;

    logic clk;
    logic rst_n;

    tsra_trade_if trade_ch ();
    tsra_cfg_if   cfg_ch ();
    tsra_run_if   run_ch ();

    trade_side_run_aggregator_unit DUT (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_trade (trade_ch),
        .i_cfg   (cfg_ch),
        .o_run   (run_ch)
    );

    // predictor state: the open run and the id threshold
    t_run_state  acc_run;
    logic        acc_open;
    logic [62:0] min_id_model;

    // finished runs still to come out of the block, oldest first
    t_run pending_runs[$];
    t_run seen_run;
    t_run want_run;

    int errors;
    int trades_sent;
    int runs_checked;
    int threshold_writes;

    // idling controls shared between the stimulus and the receiver
    bit tx_idle_en;
    bit rx_idle_en;
    int rx_hold;    // long receiver hold-off, counted down by the receiver
    int rx_gap;

    // 10 ns clock
    initial clk = 1'b0;
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor: filter, then close the other side's run, then start or
    // extend the open run, then flush on end of batch.
    // ------------------------------------------------------------------
    function automatic void predict_runs(input t_trade tr);
        logic [63:0] prod;
        logic [62:0] vol;
        logic [40:0] qsum;
        logic [63:0] vsum;
        t_run        word;
        prod = {32'd0, tr.price} * {32'd0, tr.quantity};
        // a single product at or above 2^63 is clamped
        vol  = (prod > {1'b0, VOL_SAT}) ? VOL_SAT : prod[62:0];
        if (tr.id >= min_id_model) begin
            if (acc_open && acc_run.side == tr.side) begin
                acc_run.final_price = tr.price;
                acc_run.final_id    = tr.id;
                acc_run.final_time  = tr.stamp;
                qsum = {1'b0, acc_run.qty_sum} + {9'd0, tr.quantity};
                acc_run.qty_sum = (qsum > {1'b0, QTY_SAT}) ? QTY_SAT : qsum[39:0];
                vsum = {1'b0, acc_run.vol_sum} + {1'b0, vol};
                acc_run.vol_sum = (vsum > {1'b0, VOL_SAT}) ? VOL_SAT : vsum[62:0];
            end else begin
                // side change closes the open run
                if (acc_open) begin
                    word.run  = acc_run;
                    word.last = 1'b0;
                    pending_runs = {pending_runs, word};
                end
                acc_open            = 1'b1;
                acc_run.side        = tr.side;
                acc_run.first_price = tr.price;
                acc_run.final_price = tr.price;
                acc_run.qty_sum     = {8'd0, tr.quantity};
                acc_run.vol_sum     = vol;
                acc_run.first_id    = tr.id;
                acc_run.final_id    = tr.id;
                acc_run.first_time  = tr.stamp;
                acc_run.final_time  = tr.stamp;
            end
        end
        // end of batch flushes even when the trade itself was dropped
        if (tr.eob && acc_open) begin
            word.run  = acc_run;
            word.last = 1'b1;
            pending_runs = {pending_runs, word};
            acc_open  = 1'b0;
        end
    endfunction

    // ------------------------------------------------------------------
    // Random helpers
    // ------------------------------------------------------------------
    function automatic logic [62:0] rand63();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[62:0];
    endfunction

    // price or quantity word, weighted towards the edges
    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 3))
            0: return 32'hFFFF_FFFF - $urandom_range(0, 3);
            1: return $urandom_range(0, 300);
            default: return $urandom;
        endcase
    endfunction

    function automatic t_trade mk_trade(input logic side, input logic [31:0] price,
                                        input logic [31:0] quantity, input logic [62:0] id,
                                        input logic [62:0] stamp, input logic eob);
        t_trade tr;
        tr.side     = side;
        tr.price    = price;
        tr.quantity = quantity;
        tr.id       = id;
        tr.stamp    = stamp;
        tr.eob      = eob;
        return tr;
    endfunction

    // ------------------------------------------------------------------
    // Channel tasks
    // ------------------------------------------------------------------
    // Offer one trade word and wait for it to be taken. valid stays high
    // afterwards so back-to-back words need no extra edge.
    task automatic send_trade(input t_trade tr);
        if (tx_idle_en && $urandom_range(0, 3) == 0) begin
            trade_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        trade_ch.valid          <= 1'b1;
        trade_ch.trade_side     <= tr.side;
        trade_ch.trade_price    <= tr.price;
        trade_ch.trade_quantity <= tr.quantity;
        trade_ch.trade_ref      <= tr.id;
        trade_ch.trade_time     <= tr.stamp;
        trade_ch.end_of_batch   <= tr.eob;
        do @(posedge clk); while (!trade_ch.ready);
        predict_runs(tr);
        trades_sent++;
    endtask

    // Stop offering, wait for every expected run, then let the pipe settle.
    task automatic wait_idle();
        trade_ch.valid <= 1'b0;
        while (pending_runs.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Threshold write; only issued with the block idle.
    task automatic write_min_id(input logic [62:0] value);
        cfg_ch.valid  <= 1'b1;
        cfg_ch.min_id <= value;
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        min_id_model = value;
        threshold_writes++;
        @(posedge clk);
    endtask

    // Well-formed batches (ascending ids around the threshold, random side
    // flips, end of batch mostly at the close) mixed with fully random noise words.
    task automatic send_random_batches(input int n_items);
        int          sent;
        int          blen;
        logic [62:0] id_cur;
        logic [62:0] t_cur;
        logic        side;
        logic        eob;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(0, 9) == 0) begin
                send_trade(mk_trade(1'($urandom_range(0, 1)), $urandom, $urandom, rand63(),
                                    rand63(), $urandom_range(0, 3) == 0));
                sent++;
            end else begin
                blen = $urandom_range(1, 12);
                if ($urandom_range(0, 1) == 0)
                    id_cur = (min_id_model >= 63'd3)
                             ? min_id_model - 63'($urandom_range(0, 3))
                             : min_id_model;
                else
                    id_cur = min_id_model + {31'd0, $urandom};
                t_cur = rand63() >> 1;
                side  = 1'($urandom_range(0, 1));
                for (int k = 0; k < blen; k++) begin
                    if ($urandom_range(0, 2) == 0) side = ~side;
                    eob = (k == blen - 1) ? ($urandom_range(0, 7) != 0)
                                          : ($urandom_range(0, 15) == 0);
                    send_trade(mk_trade(side, rand_word(), rand_word(), id_cur, t_cur, eob));
                    id_cur = id_cur + 63'($urandom_range(1, 4));
                    t_cur  = t_cur + 63'($urandom_range(0, 50));
                    sent++;
                end
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Receiver: random stalls plus an optional long hold-off
    // ------------------------------------------------------------------
    initial begin
        run_ch.ready = 1'b0;
        rx_gap = 0;
        forever begin
            @(posedge clk);
            if (rx_hold > 0) begin
                rx_hold--;
                run_ch.ready <= 1'b0;
            end else if (rx_gap > 0) begin
                rx_gap--;
                run_ch.ready <= 1'b0;
            end else if (rx_idle_en && $urandom_range(0, 4) == 0) begin
                rx_gap = $urandom_range(1, 14) - 1;
                run_ch.ready <= 1'b0;
            end else begin
                run_ch.ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result checker: every accepted run word against the oldest expectation
    // ------------------------------------------------------------------
    task automatic compare_field(input string name, input logic [63:0] want,
                                 input logic [63:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        end
    endtask

    always @(posedge clk) begin
        if (rst_n && run_ch.valid && run_ch.ready) begin
            seen_run.run.side        = run_ch.run_is_buy;
            seen_run.run.first_price = run_ch.first_price;
            seen_run.run.final_price = run_ch.final_price;
            seen_run.run.qty_sum     = run_ch.total_quantity;
            seen_run.run.vol_sum     = run_ch.total_volume;
            seen_run.run.first_id    = run_ch.first_id;
            seen_run.run.final_id    = run_ch.final_id;
            seen_run.run.first_time  = run_ch.first_time;
            seen_run.run.final_time  = run_ch.final_time;
            seen_run.last            = run_ch.last_of_batch;
            if (pending_runs.size() == 0) begin
                errors++;
                $display("%0t: run word with nothing expected, expected none, actual %h",
                         $time, seen_run);
            end else begin
                want_run = pending_runs.pop_front();
                compare_field("run_is_buy",     want_run.run.side,        seen_run.run.side);
                compare_field("first_price",    want_run.run.first_price, seen_run.run.first_price);
                compare_field("final_price",    want_run.run.final_price, seen_run.run.final_price);
                compare_field("total_quantity", want_run.run.qty_sum,     seen_run.run.qty_sum);
                compare_field("total_volume",   want_run.run.vol_sum,     seen_run.run.vol_sum);
                compare_field("first_id",       want_run.run.first_id,    seen_run.run.first_id);
                compare_field("final_id",       want_run.run.final_id,    seen_run.run.final_id);
                compare_field("first_time",     want_run.run.first_time,  seen_run.run.first_time);
                compare_field("final_time",     want_run.run.final_time,  seen_run.run.final_time);
                compare_field("last_of_batch",  want_run.last,            seen_run.last);
                runs_checked++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Field extremes, clamping, side change with flush, and the filter at
    // both ends of the id range.
    task automatic test_directed_cases();
        write_min_id('0);
        send_trade(mk_trade(1'b0, 32'd0, 32'd0, 63'd0, 63'd0, 1'b0));
        // biggest product clamps to the top of the volume range
        send_trade(mk_trade(1'b0, '1, '1, ID_MAX, ID_MAX, 1'b0));
        // second big product saturates the sum; id goes backwards on purpose
        send_trade(mk_trade(1'b0, '1, '1, 63'd5, 63'd5, 1'b0));
        send_trade(mk_trade(1'b1, 32'd1, '1, 63'd6, 63'd6, 1'b0));
        send_trade(mk_trade(1'b1, 32'h100, 32'h100, 63'd7, 63'd7, 1'b1));
        // end of batch on a fresh run: opens and flushes at once
        send_trade(mk_trade(1'b0, 32'h8000_0000, 32'h0000_0001, 63'd8, 63'd8, 1'b1));
        send_trade(mk_trade(1'b1, 32'h1234_5678, 32'h0000_FFFF, 63'd10, 63'd11, 1'b0));
        // side change and end of batch together: two words from one trade
        send_trade(mk_trade(1'b0, 32'h0000_0001, 32'h8765_4321, 63'd11, 63'd12, 1'b1));
        wait_idle();

        write_min_id(ID_MAX);
        // dropped trade ending a batch with nothing open: no word
        send_trade(mk_trade(1'b0, '1, '1, ID_MAX - 63'd1, 63'd1, 1'b1));
        send_trade(mk_trade(1'b1, 32'h55AA_55AA, 32'hAA55_AA55, ID_MAX, 63'd2, 1'b0));
        // dropped trade ending a batch still flushes the open run
        send_trade(mk_trade(1'b0, 32'd3, 32'd3, 63'd0, 63'd3, 1'b1));
        wait_idle();

        write_min_id(63'h1_0000_0000);
        send_trade(mk_trade(1'b1, 32'd9, 32'd9, 63'h0_FFFF_FFFF, 63'd4, 1'b0));
        send_trade(mk_trade(1'b1, 32'd10, 32'd10, 63'h1_0000_0000, 63'd5, 1'b0));
        send_trade(mk_trade(1'b0, 32'd11, 32'd11, 63'h1_0000_0001, 63'd6, 1'b1));
        wait_idle();
    endtask

    // One long buy run of near-full quantities so the quantity sum saturates.
    task automatic test_long_run();
        logic [62:0] id_cur;
        write_min_id('0);
        id_cur = rand63() >> 2;
        for (int k = 0; k < 300; k++) begin
            send_trade(mk_trade(1'b1, $urandom, $urandom | 32'hF000_0000, id_cur,
                                id_cur + 63'd7, k == 299));
            id_cur = id_cur + 63'd1;
        end
        wait_idle();
    endtask

    // Random batches under a zero and a random mid-range threshold.
    task automatic test_random_thresholds();
        write_min_id('0);
        send_random_batches(280);
        wait_idle();
        write_min_id(rand63() >> 1);
        send_random_batches(280);
        wait_idle();
    endtask

    // Receiver holds off for a long stretch while trades keep coming; every
    // trade flips side so the output queue fills and the input stalls.
    task automatic test_output_backpressure();
        logic [62:0] id_cur;
        write_min_id('0);
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        rx_hold    = 300;
        id_cur     = rand63() >> 2;
        for (int k = 0; k < 40; k++)
            send_trade(mk_trade(k[0], $urandom, $urandom, id_cur + 63'(k), id_cur + 63'(k),
                                k == 39));
        wait_idle();
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
    endtask

    // Sender pauses until the block has drained, then resumes mid-stream.
    task automatic test_sender_pause();
        send_random_batches(20);
        trade_ch.valid <= 1'b0;
        while (pending_runs.size() != 0) @(posedge clk);
        send_random_batches(20);
        wait_idle();
    endtask

    // Closing stretch at full rate on both sides.
    task automatic test_no_idle_stream();
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        send_random_batches(100);
    endtask

    // Drain, settle, then report.
    task automatic finish_run();
        int guard;
        trade_ch.valid <= 1'b0;
        guard = 0;
        while (pending_runs.size() != 0 && guard < 5000) begin
            @(posedge clk);
            guard++;
        end
        repeat (SETTLE_CYCLES * 2) @(posedge clk);
        if (pending_runs.size() != 0) begin
            errors += pending_runs.size();
            $display("%0t: runs never delivered, expected %0d more, actual 0",
                     $time, pending_runs.size());
        end
        $display("Run covered %0d trades, %0d run words checked, %0d threshold writes,",
                 trades_sent, runs_checked, threshold_writes);
        $display("including clamping, filter edges, backpressure and full-rate stretches.");
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        errors           = 0;
        trades_sent      = 0;
        runs_checked     = 0;
        threshold_writes = 0;
        rx_hold          = 0;
        tx_idle_en       = 1'b1;
        rx_idle_en       = 1'b1;
        acc_run          = '0;
        acc_open         = 1'b0;
        min_id_model     = '0;

        rst_n                   = 1'b0;
        trade_ch.valid          = 1'b0;
        trade_ch.trade_side     = 1'b0;
        trade_ch.trade_price    = '0;
        trade_ch.trade_quantity = '0;
        trade_ch.trade_ref      = '0;
        trade_ch.trade_time     = '0;
        trade_ch.end_of_batch   = 1'b0;
        cfg_ch.valid            = 1'b0;
        cfg_ch.min_id           = '0;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_cases();
        test_long_run();
        test_random_thresholds();
        test_output_backpressure();
        test_sender_pause();
        test_no_idle_stream();
        finish_run();
    end

    // Watchdog, well beyond the slowest legal run.
    initial begin
        #5_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule

### trade_side_run_aggregator_unit.f
sv/tsra_pkg.sv
sv/tsra_trade_if.sv
sv/tsra_cfg_if.sv
sv/tsra_run_if.sv
sv/tsra_out_fifo.sv
sv/trade_side_run_aggregator_unit.sv
tb/trade_side_run_aggregator_unit_test.sv
